// ===== rtl/bmq_pkg.sv =====
// Shared types and constants for the bounded multi-queue block.
// Request/result payload structs, command and result codes, config register indexes.
// No dependencies.
`default_nettype none

package bmq_pkg;

	// Defaults for the top-level parameters
	localparam int NUM_QUEUES_DEF  = 32;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int TAG_WIDTH_DEF   = 16;

	// Fixed field widths on the ports
	localparam int QSEL_W     = 5;
	localparam int TAG_PORT_W = 16;
	localparam int COUNT_W    = 4;
	localparam int CODE_W     = 3;
	localparam int QUSE_W     = 6;
	localparam int MAXQ_W     = 4;
	localparam int CFG_DATA_W = 6;

	localparam logic [QUSE_W-1:0] RESET_QUEUES_IN_USE = QUSE_W'(21);
	localparam logic [MAXQ_W-1:0] RESET_MAX_PER_QUEUE = MAXQ_W'(5);

	// Depth of the queue between front and back
	localparam int OP_FIFO_DEPTH = 2;

	typedef enum logic {
		CMD_ADD  = 1'b0,
		CMD_TAKE = 1'b1
	} cmd_t;

	typedef enum logic [CODE_W-1:0] {
		CODE_HEAD    = 3'd0,
		CODE_TAIL    = 3'd1,
		CODE_FULL    = 3'd2,
		CODE_INVALID = 3'd3,
		CODE_SERVED  = 3'd4,
		CODE_EMPTY   = 3'd5
	} result_code_t;

	typedef enum logic {
		CFG_QUEUES_IN_USE = 1'b0,
		CFG_MAX_PER_QUEUE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [QSEL_W-1:0]     queue_sel;
		logic                  urgent;
		logic [TAG_PORT_W-1:0] entry_tag;
	} req_item_t;

	typedef struct packed {
		result_code_t          result_code;
		logic [TAG_PORT_W-1:0] served_tag;
		logic [COUNT_W-1:0]    queue_count;
	} res_item_t;

	// Classified request handed from front to back
	typedef struct packed {
		req_item_t          item;
		logic               q_ok;
		logic [MAXQ_W-1:0]  limit;
	} op_t;

endpackage

`default_nettype wire

// ===== rtl/bmq_front.sv =====
// Front end: holds the config registers, accepts requests and classifies them.
// Checks the queue number, clamps the per-queue limit and pushes ops to the op queue.
// Depends on bmq_pkg.
`default_nettype none

module bmq_front import bmq_pkg::*; #(
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire req_item_t             request,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire cfg_reg_t              cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  fifo_full,
	output logic                       push,
	output op_t                        op
);

	logic [QUSE_W-1:0] queues_q;
	logic [MAXQ_W-1:0] max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queues_q <= RESET_QUEUES_IN_USE;
			max_q    <= RESET_MAX_PER_QUEUE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_QUEUES_IN_USE: queues_q <= QUSE_W'(cfg_data);
				CFG_MAX_PER_QUEUE: max_q    <= MAXQ_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign busy = fifo_full;
	assign push = start && !busy;

	always_comb begin
		op.item  = request;
		op.q_ok  = (32'(request.queue_sel) < 32'(queues_q)) &&
		           (32'(request.queue_sel) < NUM_QUEUES);
		// clamp the limit to the physical depth
		op.limit = (32'(max_q) > QUEUE_DEPTH) ? MAXQ_W'(QUEUE_DEPTH) : max_q;
	end

endmodule

`default_nettype wire

// ===== rtl/bmq_fifo.sv =====
// Short op queue between front and back, so each side stalls on its own.
// Register-based circular buffer of op_t.
// Depends on bmq_pkg.
`default_nettype none

module bmq_fifo import bmq_pkg::*; #(
	parameter int DEPTH = OP_FIFO_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output op_t       head_op
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              buf_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (fill_q == CNT_W'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign head_op   = buf_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bmq_back.sv =====
// Back end: executes one op per cycle against the per-queue head/count registers
// and the shared entry store; the result leaves in the cycle after the op is taken.
// Depends on bmq_pkg.
`default_nettype none

module bmq_back import bmq_pkg::*; #(
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_valid,
	input  wire op_t  op,
	output logic      op_pop,
	output logic      done,
	output res_item_t result
);

	localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW      = $clog2(QUEUE_DEPTH);
	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int SW      = CW + 1;
	localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW      = $clog2(SLOTS);

	logic [PW-1:0]        head_q  [NUM_QUEUES];
	logic [CW-1:0]        count_q [NUM_QUEUES];
	logic [TAG_WIDTH-1:0] store_mem [SLOTS];

	logic [QW-1:0]        qi;
	logic [PW-1:0]        cur_head;
	logic [CW-1:0]        cur_cnt;
	logic [PW-1:0]        head_dec;
	logic [PW-1:0]        head_inc;
	logic [SW-1:0]        tail_sum;
	logic [PW-1:0]        tail_slot;
	logic [PW-1:0]        slot;
	logic [AW-1:0]        addr;
	logic [PW-1:0]        new_head;
	logic [CW-1:0]        new_cnt;
	logic [CW-1:0]        out_cnt;
	logic                 upd;
	logic                 do_wr;
	logic                 do_rd;
	result_code_t         code;

	logic                 done_s1;
	result_code_t         code_s1;
	logic [COUNT_W-1:0]   cnt_s1;
	logic                 served_s1;
	logic [TAG_WIDTH-1:0] rd_data_s1;

	// results cannot be held off, so take an op whenever one is waiting
	assign op_pop = op_valid;

	assign qi       = op.q_ok ? QW'(op.item.queue_sel) : '0;
	assign cur_head = head_q[qi];
	assign cur_cnt  = count_q[qi];
	assign head_dec = (cur_head == '0) ? PW'(QUEUE_DEPTH - 1) : cur_head - PW'(1);
	assign head_inc = (cur_head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PW'(1);
	assign tail_sum = SW'(cur_head) + SW'(cur_cnt);
	// head + count stays below twice the depth: one subtract wraps it
	assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
	                                                 : PW'(tail_sum);
	assign addr = AW'(32'(qi) * QUEUE_DEPTH + 32'(slot));

	always_comb begin
		code     = CODE_INVALID;
		new_head = cur_head;
		new_cnt  = cur_cnt;
		out_cnt  = '0;
		slot     = cur_head;
		upd      = 1'b0;
		do_wr    = 1'b0;
		do_rd    = 1'b0;
		if (op.q_ok) begin
			if (op.item.cmd == CMD_ADD) begin
				out_cnt = cur_cnt;
				if (32'(cur_cnt) >= 32'(op.limit)) begin
					code = CODE_FULL;
				end else begin
					upd     = 1'b1;
					do_wr   = 1'b1;
					new_cnt = cur_cnt + CW'(1);
					out_cnt = new_cnt;
					if (op.item.urgent) begin
						new_head = head_dec;
						slot     = head_dec;
						code     = CODE_HEAD;
					end else begin
						slot = tail_slot;
						code = CODE_TAIL;
					end
				end
			end else begin
				if (cur_cnt == '0) begin
					code = CODE_EMPTY;
				end else begin
					upd      = 1'b1;
					do_rd    = 1'b1;
					new_head = head_inc;
					new_cnt  = cur_cnt - CW'(1);
					out_cnt  = new_cnt;
					code     = CODE_SERVED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (op_pop && upd) begin
			head_q[qi]  <= new_head;
			count_q[qi] <= new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && do_wr) begin
			store_mem[addr] <= TAG_WIDTH'(op.item.entry_tag);
		end
		if (op_pop && do_rd) begin
			rd_data_s1 <= store_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= op_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			code_s1   <= code;
			cnt_s1    <= COUNT_W'(out_cnt);
			served_s1 <= do_rd;
		end
	end

	assign done               = done_s1;
	assign result.result_code = code_s1;
	assign result.served_tag  = served_s1 ? TAG_PORT_W'(rd_data_s1) : '0;
	assign result.queue_count = cnt_s1;

endmodule

`default_nettype wire

// ===== rtl/bounded_multi_queue_priority_insert_top.sv =====
// Bounded multi-queue with urgent head insert: top level.
// Path: a request goes through the op queue, then the back-end result register drives done.
// Throughput: one request per cycle; the back end retires one op each cycle through
// a single entry-store port, and busy rises only when the two-entry op queue is full.
// Reset: asynchronous, clears head pointers, counts and config to defaults; the entry
// store is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module bounded_multi_queue_priority_insert_top import bmq_pkg::*; #(
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire req_item_t             request,
	output logic                       done,
	output res_item_t                  result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire cfg_reg_t              cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic fifo_full;
	logic push;
	op_t  push_op;
	logic pop;
	logic not_empty;
	op_t  head_op;

	bmq_front #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fifo_full (fifo_full),
		.push      (push),
		.op        (push_op)
	);

	bmq_fifo #(
		.DEPTH (OP_FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head_op   (head_op)
	);

	bmq_back #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (not_empty),
		.op       (head_op),
		.op_pop   (pop),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire
